FILE: hdl/sdpg_pkg.sv
// Shared types and constants for the stepper step/direction pulse generator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sdpg_pkg;

    // Width of the tick frequency register and its value after reset.
    localparam int unsigned TICK_FREQ_W = 20;
    localparam logic [TICK_FREQ_W-1:0] TICK_FREQ_RESET = 20'd10000;

    // Width of the remaining step counter.
    localparam int unsigned COUNT_W = 48;

    // Command kinds carried in the kind field of a command word.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_MOVE  = 2'd1;
    localparam logic [1:0] KIND_GOTO  = 2'd2;
    localparam logic [1:0] KIND_PAUSE = 2'd3;

    // Motion phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_ASSERT = 3'b010,
        PH_STEP   = 3'b100
    } phase_t;

    // Motion direction codes.
    typedef enum logic [1:0] {
        DIR_PAUSED = 2'b00,
        DIR_FWD    = 2'b01,
        DIR_BACK   = 2'b11
    } dir_t;

    // One command word.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] amount;
        logic [15:0]        rate;
    } cmd_word_t;

    // One result word.
    typedef struct packed {
        logic               step_level;
        logic               direction_level;
        logic               finished;
        logic               running;
        logic signed [31:0] position;
    } rsp_word_t;

endpackage

`default_nettype wire

FILE: hdl/sdpg_engine.sv
// Motion state and its update for one command word.
// Depends on sdpg_pkg for the word types, phase and direction codes.
`default_nettype none

module sdpg_engine (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           fire,
    input  wire sdpg_pkg::cmd_word_t            item,
    input  wire logic [sdpg_pkg::TICK_FREQ_W-1:0] tick_freq,
    output sdpg_pkg::rsp_word_t                 result
);
    import sdpg_pkg::*;

    phase_t                 phase_reg, phase_next;
    dir_t                   dir_reg, dir_next;
    logic [COUNT_W-1:0]     remaining_reg, remaining_next;
    logic [31:0]            position_reg, position_next;
    logic [31:0]            acc_reg, acc_next;
    logic [TICK_FREQ_W-1:0] inc_reg, inc_next;
    logic                   step_pin_reg, step_pin_next;
    logic                   dir_pin_reg, dir_pin_next;
    logic                   finished;

    logic [32:0]        acc_sum;
    logic [31:0]        acc_sat;
    logic [31:0]        thresh;
    logic [32:0]        amount_ext;
    logic [32:0]        move_mag;
    logic [32:0]        goto_diff;
    logic [32:0]        goto_mag;
    logic signed [48:0] pause_prod;
    logic [COUNT_W-1:0] pause_count;

    always_comb
    begin
        // Saturating accumulator add and the threshold it is compared against.
        acc_sum = {1'b0, acc_reg} + {{(33-TICK_FREQ_W){1'b0}}, inc_reg};
        acc_sat = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
        thresh  = {{(32-TICK_FREQ_W){1'b0}}, tick_freq};

        // Step counts for the three commands.
        amount_ext  = {item.amount[31], item.amount};
        move_mag    = item.amount[31] ? (33'd0 - amount_ext) : amount_ext;
        goto_diff   = amount_ext - {position_reg[31], position_reg};
        goto_mag    = goto_diff[32] ? (33'd0 - goto_diff) : goto_diff;
        pause_prod  = item.amount * $signed({1'b0, item.rate});
        pause_count = pause_prod[48] ? '0 : pause_prod[COUNT_W-1:0];
    end

    always_comb
    begin
        phase_next     = phase_reg;
        dir_next       = dir_reg;
        remaining_next = remaining_reg;
        position_next  = position_reg;
        acc_next       = acc_reg;
        inc_next       = inc_reg;
        step_pin_next  = step_pin_reg;
        dir_pin_next   = dir_pin_reg;
        finished       = 1'b0;

        if (fire)
        begin
            case (item.kind)
                KIND_TICK:
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                        end
                        PH_ASSERT:
                        begin
                            dir_pin_next = (dir_reg == DIR_FWD);
                            phase_next   = PH_STEP;
                        end
                        PH_STEP:
                        begin
                            if (remaining_reg == '0)
                            begin
                                phase_next    = PH_IDLE;
                                step_pin_next = 1'b0;
                                finished      = 1'b1;
                            end
                            else if (step_pin_reg)
                            begin
                                // A high step pin is always followed by a low tick.
                                acc_next      = acc_sat;
                                step_pin_next = 1'b0;
                            end
                            else if (acc_sat >= thresh)
                            begin
                                acc_next       = acc_sat - thresh;
                                step_pin_next  = (dir_reg != DIR_PAUSED);
                                remaining_next = remaining_reg - COUNT_W'(1);
                                if (dir_reg == DIR_FWD)
                                begin
                                    position_next = position_reg + 32'd1;
                                end
                                else if (dir_reg == DIR_BACK)
                                begin
                                    position_next = position_reg - 32'd1;
                                end
                            end
                            else
                            begin
                                acc_next = acc_sat;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                KIND_MOVE, KIND_GOTO:
                begin
                    if (item.kind == KIND_MOVE)
                    begin
                        dir_next       = item.amount[31] ? DIR_BACK : DIR_FWD;
                        remaining_next = {{(COUNT_W-33){1'b0}}, move_mag};
                    end
                    else
                    begin
                        dir_next       = goto_diff[32] ? DIR_BACK : DIR_FWD;
                        remaining_next = {{(COUNT_W-33){1'b0}}, goto_mag};
                    end
                    step_pin_next = 1'b0;
                    acc_next      = '0;
                    inc_next      = {{(TICK_FREQ_W-16){1'b0}}, item.rate};
                    phase_next    = PH_ASSERT;
                end
                KIND_PAUSE:
                begin
                    phase_next     = PH_STEP;
                    dir_next       = DIR_PAUSED;
                    dir_pin_next   = 1'b0;
                    acc_next       = '0;
                    inc_next       = tick_freq;
                    remaining_next = pause_count;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            dir_reg       <= DIR_FWD;
            remaining_reg <= '0;
            position_reg  <= '0;
            acc_reg       <= '0;
            inc_reg       <= '0;
            step_pin_reg  <= 1'b0;
            dir_pin_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            dir_reg       <= dir_next;
            remaining_reg <= remaining_next;
            position_reg  <= position_next;
            acc_reg       <= acc_next;
            inc_reg       <= inc_next;
            step_pin_reg  <= step_pin_next;
            dir_pin_reg   <= dir_pin_next;
        end
    end

    always_comb
    begin
        result.step_level      = step_pin_next;
        result.direction_level = dir_pin_next;
        result.finished        = finished;
        result.running         = (phase_next != PH_IDLE);
        result.position        = position_next;
    end

endmodule

`default_nettype wire

FILE: hdl/stepper_step_dir_pulse_generator.sv
// Top level of the stepper step/direction pulse generator: handshake stages
// and the tick frequency register. Depends on sdpg_pkg and sdpg_engine.
//
// The block takes one command word per clock cycle while the result side is
// not stalled, and returns exactly one result word for each. A word goes into
// an input register, the motion engine updates its state from it once the
// output register can take a result, and the result (pin levels, finished
// flag, running flag and position after that word) lands in an output
// register. Words are ticks, relative moves, absolute gotos or timed pauses;
// a new command replaces one in progress. The tick frequency register sets
// the accumulator threshold and should be written only while no word is in
// flight. The throughput of one word per cycle is set by the engine updating
// its state from each word as it fires.
`default_nettype none

module stepper_step_dir_pulse_generator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cmd_valid,
    output logic                                  cmd_stall,
    input  wire sdpg_pkg::cmd_word_t              cmd_word,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    output sdpg_pkg::rsp_word_t                   rsp_word,
    input  wire logic                             cfg_wr_en,
    input  wire logic [sdpg_pkg::TICK_FREQ_W-1:0] cfg_wr_data
);
    import sdpg_pkg::*;

    // Input stage.
    cmd_word_t cmd_reg;
    logic      cmd_valid_reg, cmd_valid_next;

    // Output stage.
    rsp_word_t rsp_reg;
    logic      rsp_valid_reg, rsp_valid_next;

    logic [TICK_FREQ_W-1:0] tick_freq_reg;

    logic      rsp_free;
    logic      fire;
    logic      cmd_take;
    rsp_word_t result;

    // The output register can take a new result when it is empty or its
    // word is leaving in this cycle. The held command moves into the engine
    // exactly then, and the input register frees up for the next word.
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign fire      = cmd_valid_reg && rsp_free;
    assign cmd_stall = cmd_valid_reg && !rsp_free;
    assign cmd_take  = cmd_valid && !cmd_stall;

    always_comb
    begin
        if (cmd_take)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (fire)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end
        rsp_valid_next = fire || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            tick_freq_reg <= TICK_FREQ_RESET;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                tick_freq_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd_word;
        end
        if (fire)
        begin
            rsp_reg <= result;
        end
    end

    sdpg_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (cmd_reg),
        .tick_freq (tick_freq_reg),
        .result    (result)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

endmodule

`default_nettype wire

FILE: hdl/sdpg_checker.sv
// Port-level checks for the stepper step/direction pulse generator, bound to
// the top level. Depends on sdpg_pkg for the word types.
`default_nettype none

module sdpg_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             cmd_valid,
    input wire logic                             cmd_stall,
    input wire sdpg_pkg::cmd_word_t              cmd_word,
    input wire logic                             rsp_valid,
    input wire logic                             rsp_stall,
    input wire sdpg_pkg::rsp_word_t              rsp_word
);
    import sdpg_pkg::*;

    logic [31:0] prev_pos_reg;
    logic        have_prev_reg;
    logic [31:0] pos_delta;
    logic        rsp_take;

    assign rsp_take  = rsp_valid && !rsp_stall;
    assign pos_delta = rsp_word.position - prev_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pos_reg  <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (rsp_take)
        begin
            prev_pos_reg  <= rsp_word.position;
            have_prev_reg <= 1'b1;
        end
    end

    // A stalled command word stays on the bus unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_word))
        else $error("stalled command word changed or dropped");

    // A stalled result word stays and holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("stalled result word changed or dropped");

    // With the output side empty, the input side never pushes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !cmd_stall)
        else $error("command stalled while no result is pending");

    // A finishing word leaves the block idle with the step pin low.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.finished |-> !rsp_word.running && !rsp_word.step_level)
        else $error("finished word shows running or step high");

    // Consecutive result words differ in position by at most one step.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_take && have_prev_reg |->
            (pos_delta == 32'd0 || pos_delta == 32'd1 || pos_delta == 32'hFFFF_FFFF))
        else $error("position moved by more than one step per word");

endmodule

bind stepper_step_dir_pulse_generator sdpg_checker u_sdpg_checker (.*);

`default_nettype wire
